// ----- rtl/core/cfc_pkg.sv -----
// Shared constants, codes and types for the centered FIR correlation block.
// Used by centered_fir_correlation, cfc_checker and tb_top; depends on nothing else.
package cfc_pkg;

    localparam int MAX_TAPS  = 64;
    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int TCNT_W    = 7;
    localparam int MAX_LEN   = 65536;
    localparam int SEEN_W    = $clog2(MAX_LEN) + 1;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 40;
    localparam int POS_W     = 16;
    localparam int FRAC_BITS = 15;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [TCNT_W-1:0] TAP_COUNT_RESET = TCNT_W'(5);

    // Input opcodes.
    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register word index (paddr[2]).
    localparam logic REG_TAP_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } cfc_state_t;

endpackage

// ----- rtl/core/cfc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the mask and the sample history.
module cfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/centered_fir_correlation.sv -----
// Centered 1-D FIR correlation with a loaded Q1.15 mask and a circular sample history.
// Depends on cfc_pkg and cfc_ram.
// Flow: words are taken only while idle (in_stall is high otherwise). Each result a sample word
// causes is summed by the single multiply-accumulate that walks the T taps in use (one per cycle)
// through the two RAM read ports. Up to (T+1)/2 results per
// sample on the last word of a run. Reset (rst_n, async, low) clears control state and sets
// tap_count to 5; history needs no clearing pass, mask contents are undefined until written.
module centered_fir_correlation (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB-style configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfc_pkg::PADDR_W-1:0]      paddr,
    input  logic [cfc_pkg::PDATA_W-1:0]      pwdata,
    output logic [cfc_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [cfc_pkg::TAP_AW-1:0]       coef_index,
    input  logic signed [cfc_pkg::SAMPLE_W-1:0] value,
    input  logic                             is_last,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cfc_pkg::POS_W-1:0]        position,
    output logic signed [cfc_pkg::SAMPLE_W-1:0] filtered,
    output logic                             last_of_run
);

    localparam int TAP_AW   = cfc_pkg::TAP_AW;
    localparam int TCNT_W   = cfc_pkg::TCNT_W;
    localparam int SEEN_W   = cfc_pkg::SEEN_W;
    localparam int SAMPLE_W = cfc_pkg::SAMPLE_W;
    localparam int PROD_W   = cfc_pkg::PROD_W;
    localparam int ACC_W    = cfc_pkg::ACC_W;
    localparam int POS_W    = cfc_pkg::POS_W;
    localparam int FRAC     = cfc_pkg::FRAC_BITS;
    localparam int R_W      = TCNT_W + 2;
    localparam int RND_W    = ACC_W + 1;
    localparam int Q_W      = RND_W - FRAC;

    // ---------------- configuration ----------------
    logic [TCNT_W-1:0] tap_count_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cfc_pkg::REG_TAP_COUNT);
    assign prdata = (paddr[2] == cfc_pkg::REG_TAP_COUNT)
                  ? cfc_pkg::PDATA_W'(tap_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= cfc_pkg::TAP_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            tap_count_reg <= pwdata[TCNT_W-1:0];
        end
    end

    // ---------------- state ----------------
    cfc_pkg::cfc_state_t state_reg, state_next;

    logic [TAP_AW-1:0] wp_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] valid_reg;
    logic [TCNT_W-1:0] t_reg;
    logic [TAP_AW-1:0] a_reg;
    logic [TAP_AW-1:0] d_reg;
    logic [TAP_AW-1:0] d_last_reg;
    logic              last_reg;
    logic [TAP_AW-1:0] i_reg;
    logic              s1_vld_reg, s1_ok_reg;
    logic              s2_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                      out_valid_reg;
    logic [POS_W-1:0]          position_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                      last_of_run_reg;

    // ---------------- accept and setup ----------------
    logic              in_accept;
    logic              smp_accept;
    logic [TCNT_W-1:0] t_eff;
    logic [TAP_AW-1:0] a_eff;
    logic [SEEN_W-1:0] seen_inc;
    logic [TAP_AW-1:0] d_first;
    logic [TAP_AW-1:0] d_last;
    logic              has_result;

    assign in_stall   = (state_reg != cfc_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign smp_accept = in_accept && (opcode == cfc_pkg::OP_SAMPLE);

    always_comb
    begin
        t_eff = tap_count_reg;
        if (tap_count_reg == '0)
        begin
            t_eff = TCNT_W'(1);
        end
        else if (tap_count_reg > TCNT_W'(cfc_pkg::MAX_TAPS))
        begin
            t_eff = TCNT_W'(cfc_pkg::MAX_TAPS);
        end
        // Taps after the center; the center is t/2.
        a_eff = TAP_AW'(t_eff - TCNT_W'(1) - (t_eff >> 1));
        seen_inc = (seen_reg == SEEN_W'(cfc_pkg::MAX_LEN)) ? seen_reg : seen_reg + SEEN_W'(1);
        // Leading outputs whose centers lie before the first sample are skipped.
        if (seen_inc <= SEEN_W'(a_eff))
        begin
            d_first = TAP_AW'(SEEN_W'(a_eff) + SEEN_W'(1) - seen_inc);
        end
        else
        begin
            d_first = '0;
        end
        d_last     = is_last ? a_eff : '0;
        has_result = (d_first <= d_last);
    end

    // ---------------- MAC addressing ----------------
    logic signed [R_W-1:0] r_idx;
    logic                  r_ok;
    logic [TAP_AW-1:0]     hist_raddr;
    logic [SAMPLE_W-1:0]   mask_rdata, hist_rdata;
    logic                  mac_done;
    logic                  pipe_empty;
    logic                  out_free;

    always_comb
    begin
        r_idx = R_W'(t_reg) - R_W'(1) - R_W'(d_reg) - R_W'(i_reg);
        // History entries older than the current run read as zero.
        r_ok  = !r_idx[R_W-1] && (SEEN_W'(r_idx[TAP_AW-1:0]) < valid_reg);
        hist_raddr = wp_reg - r_idx[TAP_AW-1:0];
    end

    assign mac_done   = (TCNT_W'(i_reg) == t_reg - TCNT_W'(1));
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    cfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (cfc_pkg::MAX_TAPS)
    ) u_mask_ram (
        .clk   (clk),
        .we    (in_accept && (opcode == cfc_pkg::OP_COEF)),
        .waddr (coef_index),
        .wdata (value),
        .raddr (i_reg),
        .rdata (mask_rdata)
    );

    cfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (cfc_pkg::MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (smp_accept),
        .waddr (wp_reg + TAP_AW'(1)),
        .wdata (value),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // ---------------- rounding of the finished sum ----------------
    logic signed [RND_W-1:0] rnd_sum;
    logic signed [Q_W-1:0]   rnd_q;
    logic signed [SAMPLE_W-1:0] rnd_sat;
    logic [SEEN_W:0]         pos_full;
    logic [POS_W-1:0]        pos_sat;

    always_comb
    begin
        rnd_sum = RND_W'(acc_reg) + RND_W'(1 << (FRAC - 1));
        rnd_q   = rnd_sum[RND_W-1:FRAC];
        if (rnd_q > Q_W'(32767))
        begin
            rnd_sat = 16'sh7FFF;
        end
        else if (rnd_q < -Q_W'(32768))
        begin
            rnd_sat = 16'sh8000;
        end
        else
        begin
            rnd_sat = rnd_q[SAMPLE_W-1:0];
        end
        pos_full = (SEEN_W + 1)'(valid_reg) - (SEEN_W + 1)'(1) - (SEEN_W + 1)'(a_reg)
                 + (SEEN_W + 1)'(d_reg);
        pos_sat  = (pos_full > (SEEN_W + 1)'(16'hFFFF)) ? 16'hFFFF : pos_full[POS_W-1:0];
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfc_pkg::ST_IDLE:
            begin
                if (smp_accept && has_result)
                begin
                    state_next = cfc_pkg::ST_MAC;
                end
            end
            cfc_pkg::ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = cfc_pkg::ST_DRAIN;
                end
            end
            cfc_pkg::ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = cfc_pkg::ST_EMIT;
                end
            end
            cfc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (d_reg == d_last_reg) ? cfc_pkg::ST_IDLE : cfc_pkg::ST_MAC;
                end
            end
            default:
            begin
                state_next = cfc_pkg::ST_IDLE;
            end
        endcase
    end

    logic issue;
    logic load_out;

    always_comb
    begin
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            cfc_pkg::ST_MAC:  issue    = 1'b1;
            cfc_pkg::ST_EMIT: load_out = out_free;
            default:
            begin
                issue    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfc_pkg::ST_IDLE;
            wp_reg        <= '0;
            seen_reg      <= '0;
            i_reg         <= '0;
            d_reg         <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            if (smp_accept)
            begin
                wp_reg   <= wp_reg + TAP_AW'(1);
                seen_reg <= is_last ? '0 : seen_inc;
                d_reg    <= d_first;
                i_reg    <= '0;
            end
            else if (issue)
            begin
                i_reg <= i_reg + TAP_AW'(1);
            end
            else if (load_out)
            begin
                d_reg <= d_reg + TAP_AW'(1);
                i_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (smp_accept)
        begin
            valid_reg  <= seen_inc;
            t_reg      <= t_eff;
            a_reg      <= a_eff;
            d_last_reg <= d_last;
            last_reg   <= is_last;
        end
        s1_ok_reg <= r_ok;
        prod_reg  <= s1_ok_reg ? PROD_W'($signed(mask_rdata) * $signed(hist_rdata)) : '0;
        if (smp_accept || load_out)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (load_out)
        begin
            position_reg    <= pos_sat;
            filtered_reg    <= rnd_sat;
            last_of_run_reg <= last_reg && (d_reg == d_last_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign filtered    = filtered_reg;
    assign last_of_run = last_of_run_reg;

    // ---------------- assertions ----------------
    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> pipe_empty)
        else $error("result loaded while the MAC pipeline still holds products");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_accept && is_last) |=> (seen_reg == '0))
        else $error("sample count not cleared at end of run");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(cfc_pkg::MAX_LEN))
        else $error("sample count beyond its saturation value");

    a_d_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cfc_pkg::ST_IDLE) |-> (d_reg <= d_last_reg))
        else $error("output offset past the last output of this word");

endmodule

// ----- verif/cfc_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for centered_fir_correlation: watches the input, output and APB channels,
// predicts each output word from its own model of the mask and delay line, and compares.
// Depends on cfc_pkg only.
module cfc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfc_pkg::PADDR_W-1:0]         paddr,
    input  logic [cfc_pkg::PDATA_W-1:0]         pwdata,
    input  logic [cfc_pkg::PDATA_W-1:0]         prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                opcode,
    input  logic [cfc_pkg::TAP_AW-1:0]          coef_index,
    input  logic signed [cfc_pkg::SAMPLE_W-1:0] value,
    input  logic                                is_last,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [cfc_pkg::POS_W-1:0]           position,
    input  logic signed [cfc_pkg::SAMPLE_W-1:0] filtered,
    input  logic                                last_of_run,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [cfc_pkg::POS_W-1:0]           pos;
        logic signed [cfc_pkg::SAMPLE_W-1:0] filt;
        logic                                last;
    } fir_out_t;

    fir_out_t                            fir_out_q[$];
    logic signed [cfc_pkg::SAMPLE_W-1:0] mask_coef [cfc_pkg::MAX_TAPS];
    logic signed [cfc_pkg::SAMPLE_W-1:0] delay_line [cfc_pkg::MAX_TAPS];
    logic [cfc_pkg::SEEN_W-1:0]          run_length;
    logic [cfc_pkg::TCNT_W-1:0]          tap_cfg;
    int                                  mismatches = 0;
    int                                  queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    initial
    begin
        foreach (mask_coef[k])
            mask_coef[k] = '0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_run();
        foreach (delay_line[k])
            delay_line[k] = '0;
        run_length = '0;
    endfunction

    // Shift one sample into the delay line and queue every output it completes.
    function automatic void correlate_sample(input logic signed [cfc_pkg::SAMPLE_W-1:0] smp,
                                             input logic fin);
        int       taps;
        int       ahead;
        int       seen_n;
        int       first_d;
        int       last_d;
        int       d;
        int       i;
        int       r;
        int       pos;
        int       k;
        longint   acc;
        longint   rnd;
        fir_out_t res;

        for (k = cfc_pkg::MAX_TAPS - 1; k > 0; k--)
            delay_line[k] = delay_line[k-1];
        delay_line[0] = smp;
        if (run_length < cfc_pkg::MAX_LEN)
            run_length = run_length + 1'b1;

        taps = tap_cfg;
        if (taps < 1)
            taps = 1;
        if (taps > cfc_pkg::MAX_TAPS)
            taps = cfc_pkg::MAX_TAPS;
        ahead   = taps - 1 - taps / 2;
        seen_n  = run_length;
        first_d = (ahead + 1 - seen_n > 0) ? ahead + 1 - seen_n : 0;
        last_d  = fin ? ahead : 0;

        for (d = first_d; d <= last_d; d++)
        begin
            acc = 0;
            for (i = 0; i < taps; i++)
            begin
                r = taps - 1 - d - i;
                if (r >= 0 && r < seen_n && r < cfc_pkg::MAX_TAPS)
                    acc += longint'(mask_coef[i]) * longint'(delay_line[r]);
            end
            rnd = (acc + 64'sd16384) >>> cfc_pkg::FRAC_BITS;
            if (rnd > 32767)
                rnd = 32767;
            if (rnd < -32768)
                rnd = -32768;
            pos = seen_n - 1 - ahead + d;
            if (pos > 65535)
                pos = 65535;
            res.pos  = pos[cfc_pkg::POS_W-1:0];
            res.filt = rnd[cfc_pkg::SAMPLE_W-1:0];
            res.last = fin && (d == ahead);
            fir_out_q.push_back(res);
        end

        if (fin)
            clear_run();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fir_out_t exp_word;

        if (!rst_n)
        begin
            clear_run();
            tap_cfg = cfc_pkg::TAP_COUNT_RESET;
            fir_out_q.delete();
        end
        else
        begin
            // Outputs are compared before this edge's input word is predicted.
            if (out_valid && !out_stall)
            begin
                if (fir_out_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word pos=%0d filtered=%0d last=%0b",
                                              position, filtered, last_of_run));
                end
                else
                begin
                    exp_word = fir_out_q.pop_front();
                    if (position !== exp_word.pos || filtered !== exp_word.filt ||
                        last_of_run !== exp_word.last)
                        report_mismatch($sformatf(
                            "pos=%0d/%0d filtered=%0d/%0d last=%0b/%0b (got/exp)",
                            position, exp_word.pos, filtered, exp_word.filt,
                            last_of_run, exp_word.last));
                end
            end

            if (psel && penable && pready &&
                paddr[cfc_pkg::PADDR_W-1] == cfc_pkg::REG_TAP_COUNT)
            begin
                if (pwrite)
                    tap_cfg = pwdata[cfc_pkg::TCNT_W-1:0];
                else if (prdata !== cfc_pkg::PDATA_W'(tap_cfg))
                    report_mismatch($sformatf("tap_count read %0d, expected %0d",
                                              prdata, tap_cfg));
            end

            if (in_valid && !in_stall)
            begin
                if (opcode == cfc_pkg::OP_COEF)
                    mask_coef[coef_index] = value;
                else
                    correlate_sample(value, is_last);
            end
        end
        queued = fir_out_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the centered_fir_correlation testbench: clock, reset, APB and stream stimulus,
// random stalls and the verdict. Depends on cfc_pkg, the block and cfc_checker.
module tb_top;

    localparam int     IDLE_PCT      = 18;
    localparam int     PHASE_ITEMS   = 22;
    localparam int     NUM_PHASES    = 9;
    localparam int     SETTLE_CYCLES = 2 * (cfc_pkg::MAX_TAPS + 4) + 16;
    localparam longint CYCLE_LIMIT   = 5000000;

    localparam logic [cfc_pkg::PADDR_W-1:0] TAP_COUNT_ADDR = {cfc_pkg::REG_TAP_COUNT, 2'b00};

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [cfc_pkg::PADDR_W-1:0]         paddr;
    logic [cfc_pkg::PDATA_W-1:0]         pwdata;
    logic [cfc_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_stall;
    logic                                opcode;
    logic [cfc_pkg::TAP_AW-1:0]          coef_index;
    logic signed [cfc_pkg::SAMPLE_W-1:0] value;
    logic                                is_last;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [cfc_pkg::POS_W-1:0]           position;
    logic signed [cfc_pkg::SAMPLE_W-1:0] filtered;
    logic                                last_of_run;
    int                                  fail_count;
    int                                  pending;
    int                                  idle_pct = IDLE_PCT;
    longint                              cycle_count = 0;
    int                                  tap_plan [NUM_PHASES] = '{1, 64, 0, 127, 2, 3, 6, 33, 17};

    centered_fir_correlation u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .coef_index (coef_index),
        .value      (value),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .filtered   (filtered),
        .last_of_run(last_of_run)
    );

    cfc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .coef_index (coef_index),
        .value      (value),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .filtered   (filtered),
        .last_of_run(last_of_run),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    function automatic logic signed [cfc_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(511)) - 16'd256;
            1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small coefficients so that long masks do not always saturate.
    function automatic logic signed [cfc_pkg::SAMPLE_W-1:0] rand_coef();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(4095)) - 16'd2048;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic op, input logic [cfc_pkg::TAP_AW-1:0] idx,
                             input logic signed [cfc_pkg::SAMPLE_W-1:0] val, input logic fin);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        coef_index <= idx;
        value      <= val;
        is_last    <= fin;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [cfc_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TAP_COUNT_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_tap_count(input int taps);
        apb_access(1'b1, cfc_pkg::PDATA_W'(taps));
        apb_access(1'b0, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // A sample can still be in flight after the last expected word, so allow extra time.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int n;
        int p;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        opcode     = cfc_pkg::OP_COEF;
        coef_index = '0;
        value      = '0;
        is_last    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, '0);

        // Load every tap once so that no mask read ever hits an unwritten entry.
        for (n = 0; n < cfc_pkg::MAX_TAPS; n++)
            send_word(cfc_pkg::OP_COEF, 6'(n),
                      (n == 0) ? 16'sh8000 : (n == 63) ? 16'sh7FFF : rand_coef(), 1'b0);

        // Full-scale negative mask: positive and negative saturation, edges of the run.
        for (n = 0; n < 5; n++)
            send_word(cfc_pkg::OP_COEF, 6'(n), 16'sh8000, n == 4);
        for (n = 0; n < 4; n++)
            send_word(cfc_pkg::OP_SAMPLE, '0, 16'sh8000, n == 3);
        for (n = 0; n < 3; n++)
            send_word(cfc_pkg::OP_SAMPLE, 6'h3F, 16'sh7FFF, n == 2);
        // A run of one sample, shorter than the mask.
        send_word(cfc_pkg::OP_SAMPLE, '0, 16'sh0000, 1'b1);
        // Center tap near unity: rounding of small values.
        for (n = 0; n < 5; n++)
            send_word(cfc_pkg::OP_COEF, 6'(n), (n == 2) ? 16'sh7FFF : 16'sh0000, 1'b0);
        send_word(cfc_pkg::OP_SAMPLE, '0, 16'shFFFF, 1'b0);
        send_word(cfc_pkg::OP_SAMPLE, '0, 16'sh0001, 1'b0);
        send_word(cfc_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b0);
        send_word(cfc_pkg::OP_SAMPLE, '0, 16'sh8000, 1'b1);
        settle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_tap_count((p == NUM_PHASES - 2) ? $urandom_range(1, 64) : tap_plan[p]);
            idle_pct = (p == 2) ? 0 : IDLE_PCT;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                if (n != PHASE_ITEMS - 1 && $urandom_range(99) < 20)
                    send_word(cfc_pkg::OP_COEF, 6'($urandom_range(63)), rand_coef(),
                              1'($urandom_range(1)));
                else
                    send_word(cfc_pkg::OP_SAMPLE, 6'($urandom_range(63)), rand_sample(),
                              (n == PHASE_ITEMS - 1) || ($urandom_range(99) < 10));
            end
            settle();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
